// File: hw/rtl/i64alu_pkg.sv
// ----------------------------------------------------------------------------
// i64alu_pkg
// Shared types and constants for the signed 64-bit ALU pipeline.
// ----------------------------------------------------------------------------
package i64alu_pkg;

   localparam int unsigned HALF_W = 32;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned ACT_W  = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_REM = 3'd4,
      ACT_NEG = 3'd5
   } action_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [HALF_W-1:0] a_low;
      logic [HALF_W-1:0] a_high;
      logic [HALF_W-1:0] b_low;
      logic [HALF_W-1:0] b_high;
   } req_type;

   typedef struct packed {
      logic [HALF_W-1:0] res_low;
      logic [HALF_W-1:0] res_high;
      logic              div_zero;
   } rsp_type;

endpackage

// File: hw/rtl/i64alu_if.sv
// ----------------------------------------------------------------------------
// i64alu_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface i64alu_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/i64alu_top_core.sv
// ----------------------------------------------------------------------------
// i64alu_core
// Stall-able pipeline: 64 restoring divide steps (one per stage), products
// split into 32x32 partials over three stages, final sign fix and select.
// ----------------------------------------------------------------------------
module i64alu_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  i64alu_pkg::req_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output i64alu_pkg::rsp_type out_data
);
   import i64alu_pkg::*;

   localparam int NS = WORD_W + 2;   // decode + 64 divide steps + finish

   logic              vld_ff  [NS];
   logic [ACT_W-1:0]  act_ff  [NS];
   logic [WORD_W-1:0] fast_ff [NS];  // add/sub/neg, later product
   logic [WORD_W-1:0] rem_ff  [NS];
   logic [WORD_W-1:0] quo_ff  [NS];  // dividend shifts out, quotient shifts in
   logic [WORD_W-1:0] dvs_ff  [NS];
   logic              na_ff   [NS];
   logic              nb_ff   [NS];
   logic              z_ff    [NS];
   logic [WORD_W-1:0] p0_ff, p1_ff;  // staged partial products
   logic [WORD_W-1:0] ma_ff, mb_ff;
   logic              adv;

   assign adv      = !out_valid || out_ready;
   assign in_ready = adv;

   logic [WORD_W-1:0] a, b, s0;
   always_comb begin
      a = {in_data.a_high, in_data.a_low};
      b = {in_data.b_high, in_data.b_low};
      case (in_data.action)
         ACT_ADD: s0 = a + b;
         ACT_SUB: s0 = a - b;
         ACT_NEG: s0 = '0 - a;
         default: s0 = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Divide step: shift one dividend bit into remainder, trial subtract.
   logic [WORD_W:0]   trial [NS];
   logic [WORD_W-1:0] shr   [NS];
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         shr[i]   = {rem_ff[i][WORD_W-2:0], quo_ff[i][WORD_W-1]};
         trial[i] = {rem_ff[i][WORD_W-1], shr[i]} - {1'b0, dvs_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act_ff[0]  <= in_data.action;
         fast_ff[0] <= s0;
         na_ff[0]   <= a[WORD_W-1];
         nb_ff[0]   <= b[WORD_W-1];
         z_ff[0]    <= (b == '0);
         rem_ff[0]  <= '0;
         quo_ff[0]  <= a[WORD_W-1] ? '0 - a : a;
         dvs_ff[0]  <= b[WORD_W-1] ? '0 - b : b;
         ma_ff      <= a;
         mb_ff      <= b;
         for (int i = 1; i < NS; i++) begin
            act_ff[i]  <= act_ff[i-1];
            // multiply: stage1 low/cross partials, stage2 sum into fast
            if (i == 2 && act_ff[1] == ACT_MUL) fast_ff[i] <= p0_ff + p1_ff;
            else fast_ff[i] <= fast_ff[i-1];
            na_ff[i]   <= na_ff[i-1];
            nb_ff[i]   <= nb_ff[i-1];
            z_ff[i]    <= z_ff[i-1];
            dvs_ff[i]  <= dvs_ff[i-1];
            if (i < NS - 1) begin
               if (!trial[i-1][WORD_W]) begin
                  rem_ff[i] <= trial[i-1][WORD_W-1:0];
                  quo_ff[i] <= {quo_ff[i-1][WORD_W-2:0], 1'b1};
               end else begin
                  rem_ff[i] <= shr[i-1];
                  quo_ff[i] <= {quo_ff[i-1][WORD_W-2:0], 1'b0};
               end
            end else begin
               rem_ff[i] <= rem_ff[i-1];
               quo_ff[i] <= quo_ff[i-1];
            end
         end
         p0_ff <= ma_ff[31:0] * mb_ff[31:0];
         p1_ff <= {32'(ma_ff[31:0] * mb_ff[63:32] + ma_ff[63:32] * mb_ff[31:0]),
                   32'd0};
      end
   end

   logic [WORD_W-1:0] r, q, m;
   always_comb begin
      q = quo_ff[NS-1];
      m = rem_ff[NS-1];
      case (act_ff[NS-1])
         ACT_DIV: r = z_ff[NS-1] ? '0 : ((na_ff[NS-1] ^ nb_ff[NS-1]) ? '0 - q : q);
         ACT_REM: r = z_ff[NS-1] ? '0 : (na_ff[NS-1] ? '0 - m : m);
         ACT_ADD, ACT_SUB, ACT_NEG, ACT_MUL: r = fast_ff[NS-1];
         default: r = '0;
      endcase
      out_data.res_low  = r[31:0];
      out_data.res_high = r[63:32];
      out_data.div_zero = z_ff[NS-1] &&
         (act_ff[NS-1] == ACT_DIV || act_ff[NS-1] == ACT_REM);
   end
   assign out_valid = vld_ff[NS-1];

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("result changed while stalled");
   a_dz: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.div_zero |-> out_data.res_low == '0 && out_data.res_high == '0)
      else $error("div by zero result not zero");
   a_adv: assert property (@(posedge clock) disable iff (reset)
      !out_valid |-> in_ready)
      else $error("pipeline stalled with empty output");
`endif
endmodule

// File: hw/rtl/int64_alu_from_halves.sv
// ----------------------------------------------------------------------------
// int64_alu_from_halves
// Signed 64-bit add/sub/mul/div/rem/neg on operands given as 32-bit halves.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | action, a_low, a_high, b_low, b_high
// rsp     | out | res_low, res_high, div_zero
//
// Every action passes through the same 66 register stages; one word enters
// per cycle while rsp does not stall.
// The 64 stage restoring divider sets the depth, one quotient bit per stage.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stall on rsp freezes the whole pipeline; req_ready follows rsp_ready
// whenever the last stage is full.
module int64_alu_from_halves (
   input logic clock,
   input logic reset,
   i64alu_if.sink   req,
   i64alu_if.source rsp
);
   import i64alu_pkg::*;

   req_type rq;
   rsp_type rs;

   // pack the channel into the pipeline's word
   assign rq = req.data;

   i64alu_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_data  (rq),
      .out_valid(rsp.valid),
      .out_ready(rsp.ready),
      .out_data (rs)
   );

   assign rsp.data = rs;
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the signed 64-bit ALU against a behavioral predictor: directed corner
// words, then random words under varying source/sink idling and a long sink
// hold-off that fills the pipeline and stalls req.
// ----------------------------------------------------------------------------
module tb_top;
   import i64alu_pkg::*;

   localparam int LATENCY = 66;
   localparam int LIMIT   = 400000;

   // Predict and check ALU results in order
   class alu_results_board;
      rsp_type pending[$];
      int      fails;

      function new();
         fails = 0;
      endfunction

      // Compute the expected result of one accepted request word
      function void note_request(req_type r);
         logic [63:0] a, b, q, res;
         logic [2:0]  act;
         logic        dz;
         rsp_type     e;
         a   = {r.a_high, r.a_low};
         b   = {r.b_high, r.b_low};
         act = r.action;
         res = '0;
         dz  = 1'b0;
         case (act)
            ACT_ADD: res = a + b;
            ACT_SUB: res = a - b;
            ACT_MUL: res = a * b;
            ACT_DIV, ACT_REM: begin
               if (b == 0) begin
                  dz = 1'b1;
               end else begin
                  // work on magnitudes, fix the sign afterward
                  if (act == ACT_DIV) begin
                     q   = (a[63] ? -a : a) / (b[63] ? -b : b);
                     res = (a[63] != b[63]) ? -q : q;
                  end else begin
                     q   = (a[63] ? -a : a) % (b[63] ? -b : b);
                     res = a[63] ? -q : q;
                  end
               end
            end
            ACT_NEG: res = -a;
            default: res = '0;
         endcase
         e.res_low  = res[31:0];
         e.res_high = res[63:32];
         e.div_zero = dz;
         pending.push_back(e);
      endfunction

      // Compare one accepted result word with the oldest prediction
      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word %h", got);
            fails++;
            return;
         end
         e = pending.pop_front();
         if (got.res_low !== e.res_low) begin
            $error("res_low expected %h actual %h", e.res_low, got.res_low);
            fails++;
         end
         if (got.res_high !== e.res_high) begin
            $error("res_high expected %h actual %h", e.res_high, got.res_high);
            fails++;
         end
         if (got.div_zero !== e.div_zero) begin
            $error("div_zero expected %b actual %b", e.div_zero, got.div_zero);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   i64alu_if #(.T(req_type)) req_ch ();
   i64alu_if #(.T(rsp_type)) rsp_ch ();

   int64_alu_from_halves i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #6 clock = ~clock;

   alu_results_board board = new();

   int   src_idle_pct  = 0;
   int   sink_idle_pct = 0;
   int   hold_len      = 0;     // length of the next sink hold-off
   logic hold_go       = 1'b0;  // toggled to request a hold-off
   logic hold_seen     = 1'b0;  // sink's copy of hold_go
   int   hold_cycles   = 0;     // counted in the sink process
   int   cycle_count   = 0;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Sink: drive ready with random idling or a long hold-off; check accepted words
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.data);
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_seen    <= hold_go;
         hold_cycles  <= 0;
      end else if (hold_seen != hold_go) begin
         hold_seen    <= hold_go;
         hold_cycles  <= hold_len;
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles  <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // Random 64-bit operand, biased toward corners and small values
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(9))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         2: return 64'h7FFF_FFFF_FFFF_FFFF;
         3: return 64'(signed'(32'($urandom_range(40)) - 20));
         4: return {32'h0, $urandom()};
         5: return {{32{1'b1}}, $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Offer one word and hold it until accepted
   task automatic send_word(logic [2:0] act, logic [63:0] a, logic [63:0] b);
      req_type r;
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      r.action = act;
      r.a_low  = a[31:0];
      r.a_high = a[63:32];
      r.b_low  = b[31:0];
      r.b_high = b[63:32];
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
   endtask

   task automatic send_random(int n);
      logic [2:0] act;
      repeat (n) begin
         act = 3'($urandom_range(7));
         send_word(act, pick_operand(), ($urandom_range(15) == 0) ? 64'h0 : pick_operand());
      end
   endtask

   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALL1  = 64'hFFFF_FFFF_FFFF_FFFF;

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: every action, extremes, zero divisor, MIN / -1
      send_word(ACT_ADD, MAX64, 64'd1);
      send_word(ACT_ADD, ALL1, ALL1);
      send_word(ACT_SUB, MIN64, 64'd1);
      send_word(ACT_SUB, 64'd0, ALL1);
      send_word(ACT_MUL, ALL1, ALL1);
      send_word(ACT_MUL, MAX64, MAX64);
      send_word(ACT_MUL, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000);
      send_word(ACT_DIV, MIN64, ALL1);
      send_word(ACT_REM, MIN64, ALL1);
      send_word(ACT_DIV, MAX64, 64'd0);
      send_word(ACT_REM, MIN64, 64'd0);
      send_word(ACT_DIV, -64'sd7, 64'd2);
      send_word(ACT_REM, -64'sd7, 64'd2);
      send_word(ACT_DIV, 64'd7, -64'sd2);
      send_word(ACT_REM, 64'd7, -64'sd2);
      send_word(ACT_DIV, MIN64, MIN64);
      send_word(ACT_REM, MAX64, MIN64);
      send_word(ACT_NEG, MIN64, 64'd0);
      send_word(ACT_NEG, ALL1, ALL1);
      send_word(3'd6, ALL1, ALL1);
      send_word(3'd7, MIN64, ALL1);
      send_word(ACT_NEG, 64'd0, 64'd0);

      // Phase one: light source idling, heavy sink idling
      src_idle_pct = 15; sink_idle_pct = 59;
      send_random(230);
      // Long sink hold-off while the source keeps offering
      hold_len = 200;
      hold_go  = ~hold_go;
      send_random(100);
      // Phase two: roles swapped
      src_idle_pct = 59; sink_idle_pct = 15;
      send_random(180);
      // Phase three: no idling
      src_idle_pct = 0; sink_idle_pct = 0;
      send_random(190);
      req_ch.valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.fails == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
